@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and gated by rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ sv/b64d_pkg.sv @@
// ---------------------------------------------------------------------------
// b64d_pkg
// Types, constants and helpers of the checked base64 decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int COUNT_XW    = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    localparam logic [7:0] PAD_CHAR  = 8'h3D;
    localparam logic [7:0] NUL_CHAR  = 8'h00;

    typedef enum logic [2:0] {
        MODE_DECODING = 3'b001,
        MODE_PADDING  = 3'b010,
        MODE_IGNORING = 3'b100
    } scan_mode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_CHAR  = 3'd1,
        ST_TRUNCATED = 3'd2,
        ST_LEFTOVER  = 3'd3,
        ST_BAD_PAD   = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]             phase;
        logic [7:0]             partial;
        scan_mode_t             mode;
        logic                   pad_due;
        status_t                err;
        logic [COUNT_WIDTH-1:0] count;
    } dec_state_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        is_final;
        logic [2:0]  status;
        logic [15:0] byte_count;
    } dec_result_t;

    localparam dec_state_t STATE_RESET = '{
        phase:   2'd0,
        partial: 8'd0,
        mode:    MODE_DECODING,
        pad_due: 1'b0,
        err:     ST_OK,
        count:   '0
    };

    // Sextet value in [5:0]; bit 6 flags a character outside the alphabet.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] d;
        begin
            d = 7'd64;
            priority if (c >= 8'h41 && c <= 8'h5A)
                d = 7'(c - 8'h41);
            else if (c >= 8'h61 && c <= 8'h7A)
                d = 7'(c - 8'h61 + 8'd26);
            else if (c >= 8'h30 && c <= 8'h39)
                d = 7'(c - 8'h30 + 8'd52);
            else if (c == 8'h2B)
                d = 7'd62;
            else if (c == 8'h2F)
                d = 7'd63;
            else
                d = 7'd64;
            return d;
        end
    endfunction

    function automatic logic [15:0] sat_count(input logic [COUNT_WIDTH-1:0] c);
        logic [COUNT_XW-1:0] e;
        begin
            e = COUNT_XW'(c);
            return (e > COUNT_XW'(16'hFFFF)) ? 16'hFFFF : e[15:0];
        end
    endfunction

endpackage

`default_nettype wire

@@ sv/b64d_if.sv @@
// ---------------------------------------------------------------------------
// b64d_in_if / b64d_out_if
// Valid/ready channels for characters in and decoded results out.
// ---------------------------------------------------------------------------
`default_nettype none

interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       end_of_text;

    modport source (output valid, output in_char, output end_of_text, input ready);
    modport sink   (input valid, input in_char, input end_of_text, output ready);
endinterface

interface b64d_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        is_final;
    logic [2:0]  status;
    logic [15:0] byte_count;

    modport source (output valid, output out_byte, output byte_valid, output is_final,
                    output status, output byte_count, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input is_final,
                    input status, input byte_count, output ready);
endinterface

`default_nettype wire

@@ sv/b64d_step.sv @@
// ---------------------------------------------------------------------------
// b64d_step
// Next-state and result logic for one character of the text.
// ---------------------------------------------------------------------------
`default_nettype none

module b64d_step
    import b64d_pkg::*;
(
    input  dec_state_t  state,
    input  logic [7:0]  in_char,
    input  logic        end_of_text,
    output dec_state_t  state_next,
    output dec_result_t result,
    output logic        has_result
);

    function automatic dec_state_t close_data(input dec_state_t s, input logic is_pad);
        dec_state_t r;
        begin
            r = s;
            priority if (s.phase == 2'd0)
                r.mode = MODE_IGNORING;
            else if (s.phase == 2'd1)
                r.err = ST_TRUNCATED;
            else if (s.partial != 8'd0)
                r.err = ST_LEFTOVER;
            else if (is_pad)
            begin
                r.mode    = MODE_PADDING;
                r.pad_due = (s.phase == 2'd2);
            end
            else
                r.err = ST_BAD_PAD;
            return r;
        end
    endfunction

    dec_state_t s;
    logic [6:0] d;
    logic       have_byte;
    logic [7:0] byte_val;

    always_comb
    begin
        s         = state;
        d         = sextet_of(in_char);
        have_byte = 1'b0;
        byte_val  = 8'd0;

        if (state.err == ST_OK)
        begin
            unique case (state.mode)
                MODE_DECODING:
                begin
                    if (in_char == NUL_CHAR || in_char == PAD_CHAR)
                        s = close_data(state, in_char == PAD_CHAR);
                    else if (d[6])
                        s.err = ST_BAD_CHAR;
                    else
                    begin
                        unique case (state.phase)
                            2'd0:
                            begin
                                s.partial = {d[5:0], 2'b00};
                            end
                            2'd1:
                            begin
                                byte_val  = state.partial | {6'd0, d[5:4]};
                                s.partial = {d[3:0], 4'd0};
                                have_byte = 1'b1;
                            end
                            2'd2:
                            begin
                                byte_val  = state.partial | {4'd0, d[5:2]};
                                s.partial = {d[1:0], 6'd0};
                                have_byte = 1'b1;
                            end
                            default:
                            begin
                                byte_val  = state.partial | {2'd0, d[5:0]};
                                s.partial = 8'd0;
                                have_byte = 1'b1;
                            end
                        endcase
                        s.phase = state.phase + 2'd1;
                        if (have_byte && state.count != '1)
                            s.count = state.count + COUNT_WIDTH'(1);
                    end
                end
                MODE_PADDING:
                begin
                    priority if (in_char == PAD_CHAR && state.pad_due)
                        s.pad_due = 1'b0;
                    else if (in_char == NUL_CHAR && !state.pad_due)
                        s.mode = MODE_IGNORING;
                    else
                        s.err = ST_BAD_PAD;
                end
                default:
                begin
                    s = state;
                end
            endcase
        end

        if (end_of_text && s.err == ST_OK)
        begin
            if (s.mode == MODE_DECODING)
                s = close_data(s, 1'b0);
            else if (s.mode == MODE_PADDING && s.pad_due)
                s.err = ST_BAD_PAD;
        end

        has_result        = have_byte || end_of_text;
        result.out_byte   = byte_val;
        result.byte_valid = have_byte;
        result.is_final   = end_of_text;
        result.status     = s.err;
        result.byte_count = sat_count(s.count);

        state_next = end_of_text ? STATE_RESET : s;
    end

endmodule

`default_nettype wire

@@ sv/base64_decoder_checked_core.sv @@
// ---------------------------------------------------------------------------
// base64_decoder_checked_core
// Streaming base64 decoder with alphabet, group and padding checks.
// ---------------------------------------------------------------------------
// One character enters per cycle and one result word leaves per cycle at
// most; a character passes first through the input register and then the
// result register. A result word appears for each completed byte and for
// the character flagged end_of_text, which carries the status and the
// saturated byte count and returns the decoder to its reset state. The
// decoder state loop is one register level deep, so a new character
// follows in the next cycle; the input stalls only while both the input
// register and the result register hold words and out_ch.ready is low.
`default_nettype none

module base64_decoder_checked_core
    import b64d_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    b64d_in_if.sink         in_ch,
    b64d_out_if.source      out_ch
);

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_last_reg;
    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_result_t step_result;
    logic        step_has_result;
    logic        out_valid_reg;
    dec_result_t out_data_reg;
    logic        out_free;
    logic        fire;

    b64d_step u_step (
        .state       (state_reg),
        .in_char     (in_char_reg),
        .end_of_text (in_last_reg),
        .state_next  (state_next),
        .result      (step_result),
        .has_result  (step_has_result)
    );

    assign out_free     = !out_valid_reg || out_ch.ready;
    assign fire         = in_valid_reg && out_free;
    assign in_ch.ready  = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
                in_valid_reg <= in_ch.valid;
            if (fire)
                state_reg <= state_next;
            if (fire && step_has_result)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_char_reg <= in_ch.in_char;
            in_last_reg <= in_ch.end_of_text;
        end
        if (fire && step_has_result)
            out_data_reg <= step_result;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_byte   = out_data_reg.out_byte;
    assign out_ch.byte_valid = out_data_reg.byte_valid;
    assign out_ch.is_final   = out_data_reg.is_final;
    assign out_ch.status     = out_data_reg.status;
    assign out_ch.byte_count = out_data_reg.byte_count;

`include "assert_macros.svh"

    `ASSERT_NEXT(a_out_hold, out_valid_reg && !out_ch.ready,
        out_valid_reg && $stable(out_data_reg), "result word changed while stalled")
    `ASSERT_IMPLIES(a_word_has_cause, out_valid_reg,
        out_data_reg.byte_valid || out_data_reg.is_final, "empty result word")
    `ASSERT_NEXT(a_final_resets, fire && in_last_reg,
        state_reg == STATE_RESET, "state not cleared after final character")
    `ASSERT_IMPLIES(a_stall_cause, !in_ch.ready,
        in_valid_reg && out_valid_reg && !out_ch.ready, "input stalled without cause")

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for base64_decoder_checked_core: a directed table,
// then random texts with well-formed groups, padding, terminators and noise,
// part of them at full rate on both sides. Each word leaving the decoder is
// compared field by field against the table or an in-bench decoder model.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
    import b64d_pkg::*;
();

    localparam int IDLE_PCT     = 30;
    localparam int RANDOM_ITEMS = 1320;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PRINT_LIMIT  = 20;

    typedef struct packed {
        logic [7:0]  ch;
        logic        eot;
        logic        typed;
        dec_result_t want;
    } stim_row_t;

    localparam stim_row_t DIRECTED [0:26] = '{
        '{"/", 1'b0, 1'b0, '0},
        '{"+", 1'b0, 1'b0, '0},
        '{"9", 1'b0, 1'b0, '0},
        '{"z", 1'b0, 1'b0, '0},
        '{"a", 1'b0, 1'b0, '0},
        '{"A", 1'b0, 1'b0, '0},
        '{"0", 1'b0, 1'b0, '0},
        '{"Z", 1'b0, 1'b0, '0},
        '{"=", 1'b0, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_OK, 16'd6}},
        '{"Q", 1'b0, 1'b0, '0},
        '{"!", 1'b0, 1'b0, '0},
        '{"Q", 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_BAD_CHAR, 16'd0}},
        '{"Q", 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_TRUNCATED, 16'd0}},
        '{"Q", 1'b0, 1'b0, '0},
        '{"R", 1'b1, 1'b1, '{8'h41, 1'b1, 1'b1, ST_LEFTOVER, 16'd1}},
        '{"Q", 1'b0, 1'b0, '0},
        '{"Q", 1'b0, 1'b0, '0},
        '{"=", 1'b0, 1'b0, '0},
        '{"=", 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_OK, 16'd1}},
        '{"Q", 1'b0, 1'b0, '0},
        '{"U", 1'b0, 1'b0, '0},
        '{"E", 1'b0, 1'b0, '0},
        '{"=", 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_OK, 16'd2}},
        '{"Q", 1'b0, 1'b0, '0},
        '{"Q", 1'b0, 1'b0, '0},
        '{NUL_CHAR, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_BAD_PAD, 16'd1}}
    };

    logic clk;
    logic rst_n;

    b64d_in_if  in_ch ();
    b64d_out_if out_ch ();

    base64_decoder_checked_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    logic [1:0]             dec_phase;
    logic [7:0]             dec_partial;
    scan_mode_t             dec_mode;
    logic [1:0]             pads_left;
    status_t                first_error;
    logic [COUNT_WIDTH-1:0] byte_total;

    dec_result_t decoded_words [$];
    dec_result_t oldest_word;
    logic [7:0]  text_q [$];
    logic        calm;
    int          mismatches;
    int          cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void clear_decoder();
        dec_phase   = 2'd0;
        dec_partial = 8'd0;
        dec_mode    = MODE_DECODING;
        pads_left   = 2'd0;
        first_error = ST_OK;
        byte_total  = '0;
    endfunction

    function automatic logic [6:0] char_value(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return 7'(c - 8'd65);
        if (c >= "a" && c <= "z")
            return 7'(c - 8'd71);
        if (c >= "0" && c <= "9")
            return 7'(c + 8'd4);
        if (c == "+")
            return 7'd62;
        if (c == "/")
            return 7'd63;
        return 7'd64;
    endfunction

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        if (v < 6'd26)
            return 8'd65 + 8'(v);
        if (v < 6'd52)
            return 8'd71 + 8'(v);
        if (v < 6'd62)
            return 8'(v) - 8'd4;
        return (v == 6'd62) ? "+" : "/";
    endfunction

    function automatic void end_data(input logic by_pad);
        if (dec_phase == 2'd0)
            dec_mode = MODE_IGNORING;
        else if (dec_phase == 2'd1)
            first_error = ST_TRUNCATED;
        else if (dec_partial != 8'd0)
            first_error = ST_LEFTOVER;
        else if (by_pad)
        begin
            dec_mode  = MODE_PADDING;
            pads_left = (dec_phase == 2'd2) ? 2'd1 : 2'd0;
        end
        else
            first_error = ST_BAD_PAD;
    endfunction

    function automatic bit decode_char(input logic [7:0] c, input logic last,
                                       output dec_result_t r);
        logic [6:0] d;
        logic       have;
        logic [7:0] b;
        have = 1'b0;
        b    = 8'd0;
        r    = '0;
        if (first_error == ST_OK)
        begin
            if (dec_mode == MODE_DECODING)
            begin
                if (c == NUL_CHAR || c == PAD_CHAR)
                    end_data(c == PAD_CHAR);
                else
                begin
                    d = char_value(c);
                    if (d[6])
                        first_error = ST_BAD_CHAR;
                    else
                    begin
                        case (dec_phase)
                            2'd0:
                            begin
                                dec_partial = {d[5:0], 2'b00};
                            end
                            2'd1:
                            begin
                                b           = dec_partial | {6'd0, d[5:4]};
                                dec_partial = {d[3:0], 4'd0};
                                have        = 1'b1;
                            end
                            2'd2:
                            begin
                                b           = dec_partial | {4'd0, d[5:2]};
                                dec_partial = {d[1:0], 6'd0};
                                have        = 1'b1;
                            end
                            default:
                            begin
                                b           = dec_partial | {2'd0, d[5:0]};
                                dec_partial = 8'd0;
                                have        = 1'b1;
                            end
                        endcase
                        dec_phase = dec_phase + 2'd1;
                        if (have && byte_total != '1)
                            byte_total = byte_total + COUNT_WIDTH'(1);
                    end
                end
            end
            else if (dec_mode == MODE_PADDING)
            begin
                if (c == PAD_CHAR && pads_left != 2'd0)
                    pads_left = pads_left - 2'd1;
                else if (c == NUL_CHAR && pads_left == 2'd0)
                    dec_mode = MODE_IGNORING;
                else
                    first_error = ST_BAD_PAD;
            end
        end
        if (last && first_error == ST_OK)
        begin
            if (dec_mode == MODE_DECODING)
                end_data(1'b0);
            else if (dec_mode == MODE_PADDING && pads_left != 2'd0)
                first_error = ST_BAD_PAD;
        end
        if (!have && !last)
            return 1'b0;
        r.out_byte   = b;
        r.byte_valid = have;
        r.is_final   = last;
        r.status     = first_error;
        r.byte_count = (byte_total > 'hFFFF) ? 16'hFFFF : 16'(byte_total);
        if (last)
            clear_decoder();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s got %0d want %0d",
                     cycle_count, what, got, want);
    endtask

    task automatic send_char(input logic [7:0] c, input logic eot, input logic typed,
                             input dec_result_t want);
        dec_result_t r;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < IDLE_PCT);
        end
        in_ch.valid       <= 1'b1;
        in_ch.in_char     <= c;
        in_ch.end_of_text <= eot;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (decode_char(c, eot, r) || typed)
            decoded_words.push_back(typed ? want : r);
    endtask

    task automatic send_text();
        int i;
        for (i = 0; i < text_q.size(); i++)
            send_char(text_q[i], i == text_q.size() - 1, 1'b0, '0);
    endtask

    task automatic push_junk();
        repeat ($urandom_range(0, 3))
            text_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_text();
        int         tail;
        int         n;
        logic [5:0] v;
        text_q.delete();
        repeat ($urandom_range(0, 5) * 4)
            text_q.push_back(sextet_char(6'($urandom_range(0, 63))));
        tail = $urandom_range(0, 6);
        case (tail)
            1, 2, 6:
            begin
                n = (tail == 1) ? 2 : (tail == 2) ? 3 : $urandom_range(2, 3);
                repeat (n - 1)
                    text_q.push_back(sextet_char(6'($urandom_range(0, 63))));
                v = 6'($urandom_range(0, 63));
                if ($urandom_range(0, 4) != 0)
                begin
                    if (n == 2)
                        v[3:0] = 4'd0;
                    else
                        v[1:0] = 2'd0;
                end
                text_q.push_back(sextet_char(v));
                if (tail == 6)
                    text_q.push_back(NUL_CHAR);
                else
                begin
                    repeat (4 - n)
                        text_q.push_back(PAD_CHAR);
                    if ($urandom_range(0, 3) == 0)
                    begin
                        text_q.push_back(NUL_CHAR);
                        push_junk();
                    end
                end
            end
            3:
            begin
                text_q.push_back(PAD_CHAR);
                push_junk();
            end
            4:
            begin
                text_q.push_back(NUL_CHAR);
                push_junk();
            end
            5:
            begin
                repeat ($urandom_range(1, 3))
                    text_q.push_back(sextet_char(6'($urandom_range(0, 63))));
            end
            default:
            begin
            end
        endcase
        if (text_q.size() > 1 && $urandom_range(0, 9) == 0)
            void'(text_q.pop_back());
        if (text_q.size() > 0 && $urandom_range(0, 99) < 15)
            text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
        if (text_q.size() == 0)
            text_q.push_back(8'($urandom_range(0, 255)));
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (decoded_words.size() == 0)
                report_mismatch("unexpected word", 1, 0);
            else
            begin
                oldest_word = decoded_words.pop_front();
                if (out_ch.out_byte !== oldest_word.out_byte)
                    report_mismatch("out_byte", out_ch.out_byte, oldest_word.out_byte);
                if (out_ch.byte_valid !== oldest_word.byte_valid)
                    report_mismatch("byte_valid", out_ch.byte_valid, oldest_word.byte_valid);
                if (out_ch.is_final !== oldest_word.is_final)
                    report_mismatch("is_final", out_ch.is_final, oldest_word.is_final);
                if (out_ch.status !== oldest_word.status)
                    report_mismatch("status", out_ch.status, oldest_word.status);
                if (out_ch.byte_count !== oldest_word.byte_count)
                    report_mismatch("byte_count", out_ch.byte_count, oldest_word.byte_count);
            end
        end
        out_ch.ready <= rst_n && (calm || $urandom_range(0, 99) >= IDLE_PCT);
    end

    initial
    begin
        int  i;
        int  random_sent;
        bit  paused;
        mismatches        = 0;
        calm              = 1'b0;
        random_sent       = 0;
        paused            = 1'b0;
        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.in_char     <= 8'd0;
        in_ch.end_of_text <= 1'b0;
        clear_decoder();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i <= 26; i++)
            send_char(DIRECTED[i].ch, DIRECTED[i].eot, DIRECTED[i].typed, DIRECTED[i].want);

        while (random_sent < RANDOM_ITEMS)
        begin
            if (!paused && random_sent >= RANDOM_ITEMS / 2)
            begin
                paused = 1'b1;
                in_ch.valid <= 1'b0;
                do
                    @(posedge clk);
                while (decoded_words.size() != 0);
            end
            // full rate on both sides through the second quarter
            calm = (random_sent >= RANDOM_ITEMS / 4) && (random_sent < RANDOM_ITEMS / 2);
            build_text();
            random_sent += text_q.size();
            send_text();
        end
        calm = 1'b0;

        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (decoded_words.size() != 0);
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
